[hw/rtl/vn_pkg.sv]
`timescale 1ns / 1ps

package vn_pkg;

  // number of components that take part; fields at or above it read as zero
  localparam int unsigned DIMENSION   = 3;
  localparam int unsigned FIELDS      = 3;
  localparam int unsigned COMP_W      = 16;
  localparam int unsigned SQ_W        = 32;
  localparam int unsigned UNIT_FRAC   = 14;
  localparam int unsigned OUT_W       = 16;

  // restoring divide: quotient of (sq << 28) / sum never exceeds 2^28
  localparam int unsigned DIV_STAGES  = 2 * UNIT_FRAC + 1;
  localparam int unsigned ROOT_STAGES = SQ_W / 2;
  localparam int unsigned LANE_LAT    = DIV_STAGES + ROOT_STAGES;
  localparam int unsigned LEN_DLY     = LANE_LAT - ROOT_STAGES;
  // input, square and sum registers ahead of the lanes
  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + LANE_LAT;

  typedef struct packed {
    logic [FIELDS-1:0] neg;
    logic              zero;
  } side_t;

endpackage

[hw/rtl/vn_isqrt.sv]
`timescale 1ns / 1ps

module vn_isqrt
  import vn_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   rad_i,
  output logic [OUT_W-1:0]  root_o
);

  logic [SQ_W-1:0] rem_q  [ROOT_STAGES];
  logic [SQ_W-1:0] root_q [ROOT_STAGES];

  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] rem_in;
    logic [SQ_W-1:0] root_in;
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] rem_d;
    logic [SQ_W-1:0] root_d;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign trial = root_in + BIT;

    always_comb begin
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = (root_in >> 1) + BIT;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign root_o = root_q[ROOT_STAGES-1][OUT_W-1:0];

endmodule

[hw/rtl/vn_lane.sv]
`timescale 1ns / 1ps

module vn_lane
  import vn_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   sq_i,
  input  logic [SQ_W-1:0]   sum_i,
  output logic [OUT_W-1:0]  mag_o
);

  logic [SQ_W-1:0]       rem_q  [DIV_STAGES];
  logic [SQ_W-1:0]       dsum_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] quo_q  [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [SQ_W-1:0]       rem_in;
    logic [SQ_W-1:0]       sum_in;
    logic [DIV_STAGES-1:0] quo_in;
    logic                  nbit;
    logic [SQ_W:0]         trial;
    logic [SQ_W:0]         diff;
    logic                  ge;

    // dividend is sq << 28: the first stage takes all of sq, with sq[0] as its new bit; later stages feed zeros
    if (j == 0) begin : g_first
      assign rem_in = {1'b0, sq_i[SQ_W-1:1]};
      assign sum_in = sum_i;
      assign quo_in = '0;
      assign nbit   = sq_i[0];
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign sum_in = dsum_q[j-1];
      assign quo_in = quo_q[j-1];
      assign nbit   = 1'b0;
    end

    assign trial = {rem_in, nbit};
    assign diff  = trial - {1'b0, sum_in};
    assign ge    = trial >= {1'b0, sum_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? diff[SQ_W-1:0] : trial[SQ_W-1:0];
        dsum_q[j] <= sum_in;
        quo_q[j]  <= {quo_in[DIV_STAGES-2:0], ge};
      end
    end
  end

  vn_isqrt u_root (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (SQ_W'(quo_q[DIV_STAGES-1])),
    .root_o (mag_o)
  );

endmodule

[hw/rtl/vector_normalizer.sv]
`timescale 1ns / 1ps

// Normalizes one signed Q8.8 vector per word: returns the floor of its
// Euclidean length in unsigned Q8.8 and each component divided by the exact
// length in signed Q1.14, truncated toward zero; an all-zero vector gives zero
// components and is_zero_o. One word enters per clock unless the pipeline is
// stalled, and passes three front registers, a 29-step restoring divide and a
// 16-step square root per component lane, and the output register. A stall
// on the output freezes the whole pipeline; stall_o is high only while a
// finished word waits and stall_i is held.

module vector_normalizer
  import vn_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic signed [COMP_W-1:0] comp_x_i,
  input  logic signed [COMP_W-1:0] comp_y_i,
  input  logic signed [COMP_W-1:0] comp_z_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic signed [OUT_W-1:0]  unit_x_o,
  output logic signed [OUT_W-1:0]  unit_y_o,
  output logic signed [OUT_W-1:0]  unit_z_o,
  output logic [OUT_W-1:0]         length_o,
  output logic                     is_zero_o
);

  logic                     en;
  logic                     out_v_q;
  logic [PIPE_DEPTH-1:0]    pv_q;
  logic signed [COMP_W-1:0] comp_in [FIELDS];
  logic signed [COMP_W-1:0] comp_q  [FIELDS];
  logic [SQ_W-1:0]          sq_q    [FIELDS];
  logic [SQ_W-1:0]          sq2_q   [FIELDS];
  logic [FIELDS-1:0]        neg1_q;
  logic [FIELDS-1:0]        neg2_q;
  logic [SQ_W-1:0]          sum_d;
  logic [SQ_W-1:0]          sum_q;
  logic [OUT_W-1:0]         mag     [FIELDS];
  logic [OUT_W-1:0]         root;
  logic [OUT_W-1:0]         len_q   [LEN_DLY];
  side_t                    side_q  [LANE_LAT];
  side_t                    side_d;
  side_t                    side_out;
  logic signed [OUT_W-1:0]  unit_q  [FIELDS];
  logic [OUT_W-1:0]         length_q;
  logic                     zero_q;

  assign en      = !(out_v_q && stall_i);
  assign stall_o = !en;
  assign valid_o = out_v_q;

  assign comp_in[0] = comp_x_i;
  assign comp_in[1] = comp_y_i;
  assign comp_in[2] = comp_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      pv_q    <= {pv_q[PIPE_DEPTH-2:0], valid_i};
      out_v_q <= pv_q[PIPE_DEPTH-1];
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < FIELDS; i++) begin
      sum_d = sum_d + sq_q[i];
    end
  end

  for (genvar i = 0; i < FIELDS; i++) begin : g_front
    logic signed [2*COMP_W-1:0] prod;
    assign prod = comp_q[i] * comp_q[i];

    always_ff @(posedge clk_i) begin
      if (en) begin
        comp_q[i] <= (i < DIMENSION) ? comp_in[i] : '0;
        sq_q[i]   <= SQ_W'(prod);
        neg1_q[i] <= comp_q[i][COMP_W-1];
        sq2_q[i]  <= sq_q[i];
        neg2_q[i] <= neg1_q[i];
      end
    end

    vn_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .sq_i  (sq2_q[i]),
      .sum_i (sum_q),
      .mag_o (mag[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sum_d;
    end
  end

  vn_isqrt u_len (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum_q),
    .root_o (root)
  );

  assign side_d.neg  = neg2_q;
  assign side_d.zero = (sum_q == '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      len_q[0]  <= root;
      side_q[0] <= side_d;
      for (int k = 1; k < LEN_DLY; k++) begin
        len_q[k] <= len_q[k-1];
      end
      for (int k = 1; k < LANE_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side_out = side_q[LANE_LAT-1];

  // merge: apply signs and force zero for the null vector
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < FIELDS; i++) begin
        if (side_out.zero) begin
          unit_q[i] <= '0;
        end else if (side_out.neg[i]) begin
          unit_q[i] <= -$signed(mag[i]);
        end else begin
          unit_q[i] <= $signed(mag[i]);
        end
      end
      length_q <= len_q[LEN_DLY-1];
      zero_q   <= side_out.zero;
    end
  end

  assign unit_x_o  = unit_q[0];
  assign unit_y_o  = unit_q[1];
  assign unit_z_o  = unit_q[2];
  assign length_o  = length_q;
  assign is_zero_o = zero_q;

  a_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_zero_o) |-> (length_o == '0 && unit_x_o == '0 &&
                                unit_y_o == '0 && unit_z_o == '0))
    else $error("zero vector with nonzero outputs");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !is_zero_o) |-> (length_o != '0))
    else $error("nonzero vector with zero length");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (unit_x_o <= 16'sd16384 && unit_x_o >= -16'sd16384 &&
                 unit_y_o <= 16'sd16384 && unit_y_o >= -16'sd16384 &&
                 unit_z_o <= 16'sd16384 && unit_z_o >= -16'sd16384))
    else $error("unit component out of range");

endmodule

[tb/sv/vector_normalizer_tb.sv]
`timescale 1ns / 1ps

module vector_normalizer_tb;
  import vn_pkg::*;

  typedef struct {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } vec_t;

  typedef struct {
    logic [OUT_W-1:0] ux;
    logic [OUT_W-1:0] uy;
    logic [OUT_W-1:0] uz;
    logic [OUT_W-1:0] len;
    logic             zero;
  } norm_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic signed [COMP_W-1:0] comp_x_i = '0;
  logic signed [COMP_W-1:0] comp_y_i = '0;
  logic signed [COMP_W-1:0] comp_z_i = '0;
  logic stall_o, valid_o, is_zero_o;
  logic signed [OUT_W-1:0] unit_x_o, unit_y_o, unit_z_o;
  logic [OUT_W-1:0] length_o;

  vec_t  vec_q[$];
  norm_t norm_expected[$];
  int    errors = 0;
  int    accepted = 0;
  int    checked = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    hold_send = 1'b0;
  bit    in_taken = 1'b0;
  longint cycles = 0;

  vector_normalizer u_dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic norm_t normalize(vec_t v);
    norm_t r;
    longint signed c[3];
    longint unsigned sq[3];
    longint unsigned sum;
    longint unsigned mag;
    logic [OUT_W-1:0] u[3];
    c[0] = v.x;
    c[1] = v.y;
    c[2] = v.z;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (i >= DIMENSION) c[i] = 0;
      sq[i] = c[i] * c[i];
      sum += sq[i];
    end
    for (int i = 0; i < 3; i++) begin
      mag = (sum != 0) ? int_sqrt((sq[i] << (2 * UNIT_FRAC)) / sum) : 0;
      u[i] = (c[i] < 0) ? OUT_W'(-mag) : OUT_W'(mag);
    end
    r.ux = u[0];
    r.uy = u[1];
    r.uz = u[2];
    r.len = OUT_W'(int_sqrt(sum));
    r.zero = (sum == 0);
    return r;
  endfunction

  function automatic logic [COMP_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return COMP_W'($urandom_range(0, 15)) - 16'sd8;
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: return COMP_W'($urandom_range(0, 511)) - 16'sd256;
      default: return COMP_W'($urandom);
    endcase
  endfunction

  // driver: new word at the falling edge once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!valid_i || in_taken) begin
        if (vec_q.size() != 0 && !hold_send && $urandom_range(0, 99) >= send_idle_pct) begin
          comp_x_i <= vec_q[0].x;
          comp_y_i <= vec_q[0].y;
          comp_z_i <= vec_q[0].z;
          valid_i  <= 1'b1;
          void'(vec_q.pop_front());
        end else begin
          valid_i <= 1'b0;
        end
      end
      stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    vec_t v;
    norm_t e;
    cycles <= cycles + 1;
    in_taken <= rst_ni && valid_i && !stall_o;
    if (rst_ni && valid_i && !stall_o) begin
      v.x = comp_x_i;
      v.y = comp_y_i;
      v.z = comp_z_i;
      norm_expected.push_back(normalize(v));
      accepted <= accepted + 1;
    end
    if (rst_ni && valid_o && !stall_i) begin
      if (norm_expected.size() == 0) begin
        $display("%t: unexpected word ux=%h uy=%h uz=%h len=%h z=%b", $time,
                 unit_x_o, unit_y_o, unit_z_o, length_o, is_zero_o);
        errors <= errors + 1;
      end else begin
        e = norm_expected.pop_front();
        checked <= checked + 1;
        if (e.ux !== unit_x_o || e.uy !== unit_y_o || e.uz !== unit_z_o ||
            e.len !== length_o || e.zero !== is_zero_o) begin
          $display("%t: expected ux=%h uy=%h uz=%h len=%h z=%b", $time,
                   e.ux, e.uy, e.uz, e.len, e.zero);
          $display("%t: actual   ux=%h uy=%h uz=%h len=%h z=%b", $time,
                   unit_x_o, unit_y_o, unit_z_o, length_o, is_zero_o);
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic push_vec(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    vec_q.push_back(v);
  endtask

  task automatic drain();
    while (vec_q.size() != 0 || valid_i || norm_expected.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int idle_set[4][2];
    idle_set = '{'{0, 0}, '{55, 0}, '{0, 55}, '{29, 29}};
    // directed: zero, axes, extremes, mixed signs
    push_vec(16'h0000, 16'h0000, 16'h0000);
    push_vec(16'h0001, 16'h0000, 16'h0000);
    push_vec(16'h0000, 16'hffff, 16'h0000);
    push_vec(16'h0000, 16'h0000, 16'h0001);
    push_vec(16'h7fff, 16'h0000, 16'h0000);
    push_vec(16'h8000, 16'h0000, 16'h0000);
    push_vec(16'h0000, 16'h8000, 16'h0000);
    push_vec(16'h0000, 16'h0000, 16'h8000);
    push_vec(16'h8000, 16'h8000, 16'h8000);
    push_vec(16'h7fff, 16'h7fff, 16'h7fff);
    push_vec(16'h7fff, 16'h8000, 16'h7fff);
    push_vec(16'h0100, 16'h0100, 16'h0100);
    push_vec(16'hff00, 16'h0100, 16'hff00);
    push_vec(16'h0003, 16'h0004, 16'h0000);
    push_vec(16'h0001, 16'h0001, 16'h0001);
    push_vec(16'hffff, 16'hffff, 16'hffff);
    push_vec(16'h5555, 16'haaaa, 16'h5555);
    push_vec(16'haaaa, 16'h5555, 16'haaaa);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph][0];
      recv_stall_pct = idle_set[ph][1];
      for (int i = 0; i < 400; i++) push_vec(rand_comp(), rand_comp(), rand_comp());
      if (ph == 1) begin
        // hold the sender until the pipe is empty, then resume
        while (vec_q.size() > 200) @(posedge clk_i);
        hold_send = 1'b1;
        while (norm_expected.size() != 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    $display("sent %0d vectors, checked %0d results over four idle/stall mixes",
             accepted, checked);
    if (errors == 0 && norm_expected.size() == 0) begin
      $display("vector_normalizer: match");
    end else begin
      $display("vector_normalizer: mismatch");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("vector_normalizer: mismatch");
      $finish;
    end
  end

endmodule

[files.f]
hw/rtl/vn_pkg.sv
hw/rtl/vn_isqrt.sv
hw/rtl/vn_lane.sv
hw/rtl/vector_normalizer.sv
tb/sv/vector_normalizer_tb.sv
